>>> sv/lru_kv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared types and fixed constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lru_kv_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

endpackage

>>> sv/lru_cache_key_value_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement,
// per-entry valid bits, keys, values and recency ages.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+---------------------------------------
// in_      | in  | in_tvalid/in_tready | tuser: cmd; tdata: key, value
// out_     | out | out_tvalid/tready   | tuser: hit; tdata: read_value
// cfg_     | in  | cfg_wr_en           | cfg_wr_data: capacity
//
// One item per cycle while results are accepted; each item is held in the input
// register and then moves on to the result register.
// Key match, slot choice and age update run in parallel across all entries.
// rst_n (synchronous) empties the store and sets capacity to 16.
// A stalled result holds the input register; in_tready drops only then.
//
module lru_cache_key_value_store
  import lru_kv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 16,
  parameter int VALUE_BITS  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [CFG_W-1:0]                         cfg_wr_data,  // capacity
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] in_tdata,     // key, value
  input  logic                                     in_tuser,     // cmd
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]          out_tdata,    // read_value
  output logic                                     out_tuser     // hit
);

  localparam int OUT_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam int AGE_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]      cap_r;
  logic                  s1_valid_r;
  cmd_t                  s1_cmd_r;
  logic [KEY_BITS-1:0]   s1_key_r;
  logic [VALUE_BITS-1:0] s1_val_r;

  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [KEY_BITS-1:0]    key_r [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]  val_r [MAX_ENTRIES];
  logic [AGE_W-1:0]       age_r [MAX_ENTRIES];
  logic [AGE_W-1:0]       age_nxt [MAX_ENTRIES];
  logic [CNT_W-1:0]       used_r, used_nxt;

  logic                  out_valid_r;
  logic                  out_hit_r, out_hit_nxt;
  logic [VALUE_BITS-1:0] out_data_r, out_data_nxt;

  logic                   advance;
  logic [MAX_ENTRIES-1:0] hit_vec, hit_oh, free_oh, old_vec, lru_oh, tgt_oh;
  logic                   any_hit, any_old, fill, touch, wr_key, wr_val, tgt_valid;
  logic [AGE_W-1:0]       old_age, lru_age;
  logic [VALUE_BITS-1:0]  hit_data;
  logic [CMP_W-1:0]       cap_ext, eff_cap, used_ext, max_ext;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  always_comb begin
    hit_data = '0;
    old_age  = '0;
    lru_age  = AGE_W'(used_r - CNT_W'(1));
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == s1_key_r);
      old_vec[i] = valid_r[i] && (age_r[i] == lru_age);
    end
    hit_oh  = hit_vec & (~hit_vec + MAX_ENTRIES'(1));
    free_oh = ~valid_r & (valid_r + MAX_ENTRIES'(1));
    any_hit = |hit_vec;
    any_old = |old_vec;
    lru_oh  = any_old ? (old_vec & (~old_vec + MAX_ENTRIES'(1))) : MAX_ENTRIES'(1);

    cap_ext  = CMP_W'(cap_r);
    max_ext  = CMP_W'(MAX_ENTRIES);
    used_ext = CMP_W'(used_r);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > max_ext) begin
      eff_cap = max_ext;
    end else begin
      eff_cap = cap_ext;
    end
    fill = (used_ext < eff_cap) && (|free_oh);

    touch  = 1'b0;
    wr_key = 1'b0;
    wr_val = 1'b0;
    tgt_oh = hit_oh;
    case (s1_cmd_r)
      CMD_GET: begin
        touch = any_hit;
      end
      CMD_PUT: begin
        touch  = 1'b1;
        wr_val = 1'b1;
        if (!any_hit) begin
          wr_key = 1'b1;
          tgt_oh = fill ? free_oh : lru_oh;
        end
      end
      default: begin
        touch = 1'b0;
      end
    endcase

    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_oh[i]) begin
        hit_data = hit_data | val_r[i];
      end
      if (tgt_oh[i]) begin
        old_age = old_age | age_r[i];
      end
    end
    tgt_valid = |(tgt_oh & valid_r);

    valid_nxt = valid_r;
    used_nxt  = used_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
    end
    if (advance && touch) begin
      valid_nxt = valid_r | tgt_oh;
      if (!tgt_valid) begin
        used_nxt = used_r + CNT_W'(1);
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (tgt_oh[i]) begin
          age_nxt[i] = '0;
        end else if (valid_r[i] && (!tgt_valid || age_r[i] < old_age)) begin
          age_nxt[i] = age_r[i] + AGE_W'(1);
        end
      end
    end

    out_hit_nxt  = any_hit;
    out_data_nxt = (s1_cmd_r == CMD_GET && any_hit) ? hit_data : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      used_r      <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r <= cmd_t'(in_tuser);
      s1_key_r <= in_tdata[KEY_BITS-1:0];
      s1_val_r <= in_tdata[KEY_BITS +: VALUE_BITS];
    end
    if (advance) begin
      out_hit_r  <= out_hit_nxt;
      out_data_r <= out_data_nxt;
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (advance && tgt_oh[i]) begin
        if (wr_key) begin
          key_r[i] <= s1_key_r;
        end
        if (wr_val) begin
          val_r[i] <= s1_val_r;
        end
      end
    end
  end

endmodule
